// ===== design/boyer_moore_search_assert.svh =====
// Assertion macros used by the checker of the Boyer-Moore search block.
`ifndef BOYER_MOORE_SEARCH_ASSERT_SVH
`define BOYER_MOORE_SEARCH_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("boyer_moore_search assertion failed");

// Consequent holds in the cycle after the antecedent.
`define BMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("boyer_moore_search assertion failed");

`endif

// ===== design/bms_pkg.sv =====
// Types, codes and controller steps of the Boyer-Moore search block.
package bms_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] index;
    logic [7:0]  value;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [11:0] position;
    logic [12:0] match_count;
  } out_t;

  localparam logic [1:0] OP_PAT_WR = 2'd0;
  localparam logic [1:0] OP_TXT_WR = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_COUNT  = 2'd3;

  localparam logic CFG_PAT_LEN = 1'b0;
  localparam logic CFG_TXT_LEN = 1'b1;

  localparam int CFG_W = 13;

  // Controller steps; the datapath acts on the current one.
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_LOCLR = 5'd1;
  localparam logic [4:0] ST_LORD  = 5'd2;
  localparam logic [4:0] ST_LOWR  = 5'd3;
  localparam logic [4:0] ST_BINIT = 5'd4;
  localparam logic [4:0] ST_OUTR  = 5'd5;
  localparam logic [4:0] ST_OUTW  = 5'd6;
  localparam logic [4:0] ST_INR   = 5'd7;
  localparam logic [4:0] ST_INW   = 5'd8;
  localparam logic [4:0] ST_DEC   = 5'd9;
  localparam logic [4:0] ST_P2R0  = 5'd10;
  localparam logic [4:0] ST_P2W0  = 5'd11;
  localparam logic [4:0] ST_P2R   = 5'd12;
  localparam logic [4:0] ST_P2W   = 5'd13;
  localparam logic [4:0] ST_CHK   = 5'd14;
  localparam logic [4:0] ST_CMP   = 5'd15;
  localparam logic [4:0] ST_CMPW  = 5'd16;
  localparam logic [4:0] ST_MATCH = 5'd17;
  localparam logic [4:0] ST_MW    = 5'd18;
  localparam logic [4:0] ST_LOW   = 5'd19;
  localparam logic [4:0] ST_DONE  = 5'd20;

  typedef struct packed {
    logic [4:0] step;
    logic       accept;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic tables_valid;
    logic lo_last;
    logic a_zero;
    logic b_le_m;
    logic pat_ne;
    logic p2_last;
    logic no_align;
    logic eq;
    logic j_zero;
    logic all;
  } sts_t;

endpackage

// ===== design/bms_ctrl.sv =====
// Controller state machine of the Boyer-Moore search block.
module bms_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    opcode_i,
  output logic          in_stall_o,
  input  logic          out_stall_i,
  input  bms_pkg::sts_t sts_i,
  output bms_pkg::cmd_t cmd_o
);

  logic [4:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = !((state_q == bms_pkg::ST_IDLE) && (!sts_i.out_valid || !out_stall_i));
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.step   = state_q;
  assign cmd_o.accept = accept;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bms_pkg::ST_IDLE: begin
        if (accept) begin
          if ((opcode_i == bms_pkg::OP_PAT_WR) || (opcode_i == bms_pkg::OP_TXT_WR)) begin
            state_d = bms_pkg::ST_DONE;
          end else if (sts_i.tables_valid) begin
            state_d = bms_pkg::ST_CHK;
          end else begin
            state_d = bms_pkg::ST_LOCLR;
          end
        end
      end
      bms_pkg::ST_LOCLR: state_d = bms_pkg::ST_LORD;
      bms_pkg::ST_LORD:  state_d = bms_pkg::ST_LOWR;
      bms_pkg::ST_LOWR:  state_d = sts_i.lo_last ? bms_pkg::ST_BINIT : bms_pkg::ST_LORD;
      bms_pkg::ST_BINIT: state_d = bms_pkg::ST_OUTR;
      bms_pkg::ST_OUTR:  state_d = sts_i.a_zero ? bms_pkg::ST_P2R0 : bms_pkg::ST_OUTW;
      bms_pkg::ST_OUTW:  state_d = bms_pkg::ST_INR;
      bms_pkg::ST_INR:   state_d = sts_i.b_le_m ? bms_pkg::ST_INW : bms_pkg::ST_DEC;
      bms_pkg::ST_INW:   state_d = sts_i.pat_ne ? bms_pkg::ST_INR : bms_pkg::ST_DEC;
      bms_pkg::ST_DEC:   state_d = bms_pkg::ST_OUTR;
      bms_pkg::ST_P2R0:  state_d = bms_pkg::ST_P2W0;
      bms_pkg::ST_P2W0:  state_d = bms_pkg::ST_P2R;
      bms_pkg::ST_P2R:   state_d = bms_pkg::ST_P2W;
      bms_pkg::ST_P2W:   state_d = sts_i.p2_last ? bms_pkg::ST_CHK : bms_pkg::ST_P2R;
      bms_pkg::ST_CHK:   state_d = sts_i.no_align ? bms_pkg::ST_DONE : bms_pkg::ST_CMP;
      bms_pkg::ST_CMP:   state_d = bms_pkg::ST_CMPW;
      bms_pkg::ST_CMPW: begin
        if (!sts_i.eq) begin
          state_d = bms_pkg::ST_LOW;
        end else if (!sts_i.j_zero) begin
          state_d = bms_pkg::ST_CMP;
        end else if (sts_i.all) begin
          state_d = bms_pkg::ST_MATCH;
        end else begin
          state_d = bms_pkg::ST_DONE;
        end
      end
      bms_pkg::ST_MATCH: state_d = bms_pkg::ST_MW;
      bms_pkg::ST_MW:    state_d = bms_pkg::ST_LOW;
      bms_pkg::ST_LOW:   state_d = bms_pkg::ST_CHK;
      bms_pkg::ST_DONE:  state_d = bms_pkg::ST_IDLE;
      default:           state_d = bms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bms_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/bms_datapath.sv =====
// Datapath of the Boyer-Moore search block: stores, shift tables and result register.
module bms_datapath #(
  parameter int TEXT_DEPTH    = 4096,
  parameter int PATTERN_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bms_pkg::cmd_t cmd_i,
  input  bms_pkg::in_t  in_data_i,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [bms_pkg::CFG_W-1:0] cfg_data_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output bms_pkg::out_t out_data_o,
  output bms_pkg::sts_t sts_o
);

  localparam int TAW = $clog2(TEXT_DEPTH);
  localparam int TW  = $clog2(TEXT_DEPTH + 1);
  localparam int PAW = $clog2(PATTERN_DEPTH);
  localparam int BW  = $clog2(PATTERN_DEPTH + 2);
  localparam int PSW = ((TW > 12) ? TW : 12) + 1;
  localparam int SD  = PATTERN_DEPTH + 2;

  logic [7:0]    text_mem [TEXT_DEPTH];
  logic [7:0]    pat_mem  [PATTERN_DEPTH];
  logic [PAW-1:0] lo_mem  [256];
  logic [BW-1:0] ss_mem   [SD];
  logic [BW-1:0] bp_mem   [SD];
  logic [255:0]  lo_vld_q;
  logic [SD-1:0] ss_vld_q;

  logic [7:0]     txt_rd, pat_rd;
  logic [PAW-1:0] lo_rd;
  logic           lo_rv, ss_rv;
  logic [BW-1:0]  ss_rd, bp_rd;

  logic [5:0]     plen_q;
  logic [12:0]    tlen_q;
  logic           tv_q;
  logic [PAW-1:0] k_q, j_q;
  logic [BW-1:0]  a_q, b_q, gs_q;
  logic [7:0]     pa_q;
  logic [PSW-1:0] pos_q;
  logic [TW-1:0]  hits_q;
  logic [11:0]    first_q;
  logic           all_q, mt_q, near_q;
  logic           ov_q;
  bms_pkg::out_t  out_q;

  logic [BW-1:0]  m;
  logic [TW-1:0]  n;
  logic [PAW-1:0] pat_ra;
  logic [TAW-1:0] txt_ra;
  logic [BW-1:0]  ss_ra, bp_ra, ss_wa, ss_wd, bp_wa, bp_wd, ss_val, bc, shift;
  logic           ss_we, bp_we, ss0;
  logic           pat_we, txt_we;
  logic [4:0]     step;
  logic [PSW:0]   pos_end;

  assign step = cmd_i.step;

  // Effective lengths after clamping the registers to the store sizes.
  always_comb begin
    if (plen_q == 6'd0) begin
      m = BW'(1);
    end else if (int'(plen_q) > PATTERN_DEPTH) begin
      m = BW'(PATTERN_DEPTH);
    end else begin
      m = BW'(plen_q);
    end
    if (int'(tlen_q) > TEXT_DEPTH) begin
      n = TW'(TEXT_DEPTH);
    end else begin
      n = TW'(tlen_q);
    end
  end

  assign pat_we = cmd_i.accept && (in_data_i.opcode == bms_pkg::OP_PAT_WR)
                  && (int'(in_data_i.index) < PATTERN_DEPTH);
  assign txt_we = cmd_i.accept && (in_data_i.opcode == bms_pkg::OP_TXT_WR)
                  && (int'(in_data_i.index) < TEXT_DEPTH);

  assign ss_val  = ss_rv ? ss_rd : '0;
  assign ss0     = (ss_val == '0);
  assign pos_end = (PSW+1)'(pos_q) + (PSW+1)'(m);

  always_comb begin
    pat_ra = j_q;
    txt_ra = TAW'(pos_q + PSW'(j_q));
    ss_ra  = BW'(j_q) + BW'(1);
    bp_ra  = b_q;
    case (step)
      bms_pkg::ST_LORD:  pat_ra = k_q;
      bms_pkg::ST_OUTR:  pat_ra = PAW'(a_q - BW'(1));
      bms_pkg::ST_INR: begin
        pat_ra = PAW'(b_q - BW'(1));
        ss_ra  = b_q;
      end
      bms_pkg::ST_P2R0:  bp_ra = '0;
      bms_pkg::ST_P2R:   ss_ra = a_q;
      bms_pkg::ST_MATCH: begin
        txt_ra = TAW'(pos_q + PSW'(m));
        ss_ra  = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    ss_we = 1'b0;
    ss_wa = b_q;
    ss_wd = b_q - a_q;
    bp_we = 1'b0;
    bp_wa = a_q - BW'(1);
    bp_wd = b_q - BW'(1);
    case (step)
      bms_pkg::ST_INW:   ss_we = (pat_rd != pa_q) && ss0;
      bms_pkg::ST_P2W: begin
        ss_we = ss0;
        ss_wa = a_q;
        ss_wd = b_q;
      end
      bms_pkg::ST_BINIT: begin
        bp_we = 1'b1;
        bp_wa = m;
        bp_wd = m + BW'(1);
      end
      bms_pkg::ST_DEC:   bp_we = 1'b1;
      default: ;
    endcase
  end

  // Bad-character distance, then the larger of the two rules.
  always_comb begin
    if (mt_q) begin
      if (near_q) begin
        bc = BW'(1);
      end else begin
        bc = lo_rv ? (m - BW'(lo_rd)) : (m + BW'(1));
      end
    end else if (!lo_rv) begin
      bc = BW'(j_q) + BW'(1);
    end else if (BW'(lo_rd) >= BW'(j_q)) begin
      bc = BW'(1);
    end else begin
      bc = BW'(j_q) - BW'(lo_rd);
    end
    shift = (bc > gs_q) ? bc : gs_q;
  end

  always_ff @(posedge clk_i) begin
    if (txt_we) begin
      text_mem[TAW'(in_data_i.index)] <= in_data_i.value;
    end
    txt_rd <= text_mem[txt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[PAW'(in_data_i.index)] <= in_data_i.value;
    end
    pat_rd <= pat_mem[pat_ra];
  end

  always_ff @(posedge clk_i) begin
    if (step == bms_pkg::ST_LOWR) begin
      lo_mem[pat_rd] <= k_q;
    end
    lo_rd <= lo_mem[txt_rd];
    lo_rv <= lo_vld_q[txt_rd];
  end

  always_ff @(posedge clk_i) begin
    if (ss_we) begin
      ss_mem[ss_wa] <= ss_wd;
    end
    ss_rd <= ss_mem[ss_ra];
    ss_rv <= ss_vld_q[ss_ra];
  end

  always_ff @(posedge clk_i) begin
    if (bp_we) begin
      bp_mem[bp_wa] <= bp_wd;
    end
    bp_rd <= bp_mem[bp_ra];
  end

  // Valid bits stand in for the -1 and zero contents after a rebuild starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_vld_q <= '0;
      ss_vld_q <= '0;
    end else if (step == bms_pkg::ST_LOCLR) begin
      lo_vld_q <= '0;
      ss_vld_q <= '0;
    end else begin
      if (step == bms_pkg::ST_LOWR) begin
        lo_vld_q[pat_rd] <= 1'b1;
      end
      if (ss_we) begin
        ss_vld_q[ss_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= 6'd1;
      tlen_q <= '0;
      tv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == bms_pkg::CFG_PAT_LEN)) begin
        plen_q <= cfg_data_i[5:0];
      end
      if (cfg_we_i && (cfg_index_i == bms_pkg::CFG_TXT_LEN)) begin
        tlen_q <= cfg_data_i;
      end
      if (pat_we || (cfg_we_i && (cfg_index_i == bms_pkg::CFG_PAT_LEN))) begin
        tv_q <= 1'b0;
      end else if ((step == bms_pkg::ST_P2W) && (a_q == m)) begin
        tv_q <= 1'b1;
      end
      if (step == bms_pkg::ST_DONE) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hits_q  <= '0;
      first_q <= '0;
      all_q   <= (in_data_i.opcode == bms_pkg::OP_COUNT);
      pos_q   <= (in_data_i.opcode == bms_pkg::OP_FIND) ? PSW'(in_data_i.index) : '0;
    end
    case (step)
      bms_pkg::ST_LOCLR: k_q <= '0;
      bms_pkg::ST_LOWR:  k_q <= k_q + PAW'(1);
      bms_pkg::ST_BINIT: begin
        a_q <= m;
        b_q <= m + BW'(1);
      end
      bms_pkg::ST_OUTW:  pa_q <= pat_rd;
      bms_pkg::ST_INW: begin
        if (pat_rd != pa_q) begin
          b_q <= bp_rd;
        end
      end
      bms_pkg::ST_DEC: begin
        a_q <= a_q - BW'(1);
        b_q <= b_q - BW'(1);
      end
      bms_pkg::ST_P2W0: begin
        b_q <= bp_rd;
        a_q <= '0;
      end
      bms_pkg::ST_P2W: begin
        if (a_q == b_q) begin
          b_q <= bp_rd;
        end
        a_q <= a_q + BW'(1);
      end
      bms_pkg::ST_CHK:   j_q <= PAW'(m - BW'(1));
      bms_pkg::ST_CMPW: begin
        if (pat_rd != txt_rd) begin
          gs_q <= ss_val;
          mt_q <= 1'b0;
        end else if (j_q != '0) begin
          j_q <= j_q - PAW'(1);
        end else begin
          if (hits_q == '0) begin
            first_q <= pos_q[11:0];
          end
          hits_q <= hits_q + TW'(1);
        end
      end
      bms_pkg::ST_MW: begin
        gs_q   <= ss_val;
        mt_q   <= 1'b1;
        near_q <= !(pos_end < (PSW+1)'(n));
      end
      bms_pkg::ST_LOW:   pos_q <= pos_q + PSW'(shift);
      default: ;
    endcase
    if (step == bms_pkg::ST_DONE) begin
      out_q.found       <= (hits_q != '0);
      out_q.position    <= first_q;
      out_q.match_count <= all_q ? 13'(hits_q) : '0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  assign sts_o.out_valid    = ov_q;
  assign sts_o.tables_valid = tv_q;
  assign sts_o.lo_last      = (BW'(k_q) == (m - BW'(1)));
  assign sts_o.a_zero       = (a_q == '0);
  assign sts_o.b_le_m       = (b_q <= m);
  assign sts_o.pat_ne       = (pat_rd != pa_q);
  assign sts_o.p2_last      = (a_q == m);
  assign sts_o.no_align     = (TW'(m) > n) || (pos_end > (PSW+1)'(n));
  assign sts_o.eq           = (pat_rd == txt_rd);
  assign sts_o.j_zero       = (j_q == '0);
  assign sts_o.all          = all_q;

endmodule

// ===== design/boyer_moore_search.sv =====
// Boyer-Moore search block: keeps a text buffer of TEXT_DEPTH bytes and a
// pattern of up to PATTERN_DEPTH bytes and answers one word for every input
// word. A search first rebuilds the last-occurrence and strong good-suffix
// tables if the pattern or its length changed since the last rebuild: a
// last-occurrence pass over the pattern, a border walk that jumps to shorter
// borders on a mismatch, and a closing pass. The scan then compares bytes
// from the pattern's end and shifts the alignment, paced by its reads, since
// every byte and table read goes through a registered memory port. One word
// is in work at a time. A waiting result holds off the next word, which is
// taken no earlier than the cycle in which that result leaves.
module boyer_moore_search #(
  parameter int TEXT_DEPTH    = 4096,
  parameter int PATTERN_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bms_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bms_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [bms_pkg::CFG_W-1:0] cfg_data_i
);

  bms_pkg::cmd_t cmd;
  bms_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  bms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (in_data_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bms_datapath #(
    .TEXT_DEPTH    (TEXT_DEPTH),
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .sts_o       (sts)
  );

endmodule

// ===== design/bms_checker.sv =====
// Port-level checker of the Boyer-Moore search block and its bind.
`include "boyer_moore_search_assert.svh"

module bms_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bms_pkg::out_t out_data_o
);

  // One word is in work at a time, so the block stalls right after taking one.
  `BMS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `BMS_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)
  `BMS_ASSERT_NOW(a_miss_is_zero, out_valid_o && !out_data_o.found,
    (out_data_o.position == 12'd0) && (out_data_o.match_count == 13'd0))
  `BMS_ASSERT_NOW(a_count_found, out_valid_o && (out_data_o.match_count != 13'd0),
    out_data_o.found)

endmodule

bind boyer_moore_search bms_checker u_bms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
